// ===== src/dssp_pkg.sv =====
// shared types, constants and helpers of the decimal string parser
package dssp_pkg;

    localparam int MANTISSA_BITS_DEF  = 64;
    localparam int EXPONENT_LIMIT_DEF = 9999;

    localparam int CHAR_W       = 8;
    localparam int MANT_FIELD_W = 64;
    localparam int EXP_VAL_W    = 14;
    localparam int FRAC_W       = 8;
    localparam int DEXP_W       = 15;
    localparam int OUT_FIELDS_W = 1 + MANT_FIELD_W + DEXP_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EDIG,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   sign_neg;
        logic [FRAC_W-1:0]      frac_cnt;
        logic                   exp_neg;
        logic [EXP_VAL_W-1:0]   exp_val;
        logic                   clamp;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:    PH_SPACE,
        sign_neg: 1'b0,
        frac_cnt: '0,
        exp_neg:  1'b0,
        exp_val:  '0,
        clamp:    1'b0
    };

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_exp_mark(input logic [CHAR_W-1:0] c);
        return (c == CH_LOW_E) || (c == CH_UP_E);
    endfunction

endpackage

// ===== src/dssp_step.sv =====
// per-character parse step: phase decode, digit accumulation and result fields
module dssp_step #(
    parameter int MANTISSA_BITS  = dssp_pkg::MANTISSA_BITS_DEF,
    parameter int EXPONENT_LIMIT = dssp_pkg::EXPONENT_LIMIT_DEF
) (
    input  logic [dssp_pkg::CHAR_W-1:0]       character,
    input  dssp_pkg::parse_state_t            cur,
    input  logic [MANTISSA_BITS-1:0]          mant_cur,
    output dssp_pkg::parse_state_t            nxt,
    output logic [MANTISSA_BITS-1:0]          mant_nxt,
    output logic [dssp_pkg::MANT_FIELD_W-1:0] res_mantissa,
    output logic [dssp_pkg::DEXP_W-1:0]       res_dexp
);

    localparam int MANT_MAC_W = MANTISSA_BITS + 4;
    localparam int EXP_MAC_W  = dssp_pkg::EXP_VAL_W + 4;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX  = {MANTISSA_BITS{1'b1}};
    localparam logic [EXP_MAC_W-1:0]     EXP_LIM_W = EXP_MAC_W'(EXPONENT_LIMIT);
    localparam logic [dssp_pkg::EXP_VAL_W-1:0] EXP_LIM =
        dssp_pkg::EXP_VAL_W'(EXPONENT_LIMIT);

    logic [3:0]                  digit;
    logic                        ch_digit;
    logic                        ch_sign;
    logic                        do_int;
    logic                        add_mant;
    logic                        add_exp;
    logic [MANT_MAC_W-1:0]       mant_wide;
    logic [MANT_MAC_W-1:0]       mant_mac;
    logic [EXP_MAC_W-1:0]        exp_wide;
    logic [EXP_MAC_W-1:0]        exp_mac;
    logic signed [dssp_pkg::DEXP_W-1:0] ev_s;
    logic signed [dssp_pkg::DEXP_W-1:0] fc_s;

    assign digit    = character[3:0];
    assign ch_digit = dssp_pkg::is_digit(character);
    assign ch_sign  = (character == dssp_pkg::CH_MINUS) || (character == dssp_pkg::CH_PLUS);

    // times ten as two shifts and an add
    assign mant_wide = {4'b0, mant_cur};
    assign mant_mac  = (mant_wide << 3) + (mant_wide << 1) + MANT_MAC_W'(digit);
    assign exp_wide  = {4'b0, cur.exp_val};
    assign exp_mac   = (exp_wide << 3) + (exp_wide << 1) + EXP_MAC_W'(digit);

    always_comb
    begin
        nxt      = cur;
        mant_nxt = mant_cur;
        do_int   = 1'b0;
        add_mant = 1'b0;
        add_exp  = 1'b0;

        unique case (cur.phase)
            dssp_pkg::PH_SPACE:
            begin
                if (!dssp_pkg::is_space(character))
                begin
                    nxt.phase = dssp_pkg::PH_INT;
                    if (ch_sign)
                        nxt.sign_neg = (character == dssp_pkg::CH_MINUS);
                    else
                        do_int = 1'b1;
                end
            end
            dssp_pkg::PH_INT:
                do_int = 1'b1;
            dssp_pkg::PH_FRAC:
            begin
                if (ch_digit)
                begin
                    add_mant = 1'b1;
                    if (cur.frac_cnt == dssp_pkg::FRAC_MAX)
                        nxt.clamp = 1'b1;
                    else
                        nxt.frac_cnt = cur.frac_cnt + 1'b1;
                end
                else if (dssp_pkg::is_exp_mark(character))
                    nxt.phase = dssp_pkg::PH_ESIGN;
                else
                    nxt.phase = dssp_pkg::PH_DONE;
            end
            dssp_pkg::PH_ESIGN:
            begin
                nxt.phase = dssp_pkg::PH_EDIG;
                if (ch_sign)
                    nxt.exp_neg = (character == dssp_pkg::CH_MINUS);
                else if (ch_digit)
                    add_exp = 1'b1;
                else
                    nxt.phase = dssp_pkg::PH_DONE;
            end
            dssp_pkg::PH_EDIG:
            begin
                if (ch_digit)
                    add_exp = 1'b1;
                else
                    nxt.phase = dssp_pkg::PH_DONE;
            end
            default:
            begin
            end
        endcase

        // integer part and whatever may follow it
        if (do_int)
        begin
            if (ch_digit)
                add_mant = 1'b1;
            else if (character == dssp_pkg::CH_POINT)
                nxt.phase = dssp_pkg::PH_FRAC;
            else if (dssp_pkg::is_exp_mark(character))
                nxt.phase = dssp_pkg::PH_ESIGN;
            else
                nxt.phase = dssp_pkg::PH_DONE;
        end

        if (add_mant)
        begin
            if (mant_mac > {4'b0, MANT_MAX})
            begin
                mant_nxt  = MANT_MAX;
                nxt.clamp = 1'b1;
            end
            else
                mant_nxt = mant_mac[MANTISSA_BITS-1:0];
        end

        if (add_exp)
        begin
            if (exp_mac > EXP_LIM_W)
            begin
                nxt.exp_val = EXP_LIM;
                nxt.clamp   = 1'b1;
            end
            else
                nxt.exp_val = exp_mac[dssp_pkg::EXP_VAL_W-1:0];
        end
    end

    // decimal exponent = signed exponent minus fraction digit count
    assign ev_s = $signed({1'b0, nxt.exp_val});
    assign fc_s = $signed({{(dssp_pkg::DEXP_W - dssp_pkg::FRAC_W){1'b0}}, nxt.frac_cnt});
    assign res_dexp     = (nxt.exp_neg ? -ev_s : ev_s) - fc_s;
    assign res_mantissa = dssp_pkg::MANT_FIELD_W'(mant_nxt);

endmodule

// ===== src/decimal_scientific_string_parser_top.sv =====
// top level of the decimal scientific-notation string parser
// Takes a decimal number as text, one ASCII character per input word, and
// returns one result word after the word marked with s_tlast: the sign, all
// integer and fraction digits as one unsigned mantissa, and the decimal
// exponent, so that value = mantissa * 10^decimal_exponent. Leading
// whitespace is skipped, then an optional sign, digits, an optional point
// with fraction digits and an optional e/E with a signed exponent; the first
// character that does not fit ends parsing and the rest up to tlast is
// ignored. The mantissa clamps at 2^MANTISSA_BITS-1, the fraction count at
// 255 and the exponent at EXPONENT_LIMIT, each setting the saturated flag.
// Throughput is one character per clock while the input is not stalled: a
// character sits in the input register while the step logic (a times-ten add
// and compare on the mantissa) folds it into the parse state. Once the last
// character may leave the input register, the result word is loaded into
// the output register. The input stalls only when a finished result waits
// on m_tready and the next last character arrives behind it. After each
// result all parse state returns to its reset value for the next string.
module decimal_scientific_string_parser_top #(
    parameter int MANTISSA_BITS  = dssp_pkg::MANTISSA_BITS_DEF,
    parameter int EXPONENT_LIMIT = dssp_pkg::EXPONENT_LIMIT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dssp_pkg::CHAR_W-1:0]      s_tdata,  // character[7:0]
    input  logic                             s_tlast,  // last character of the string
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // negative[0], mantissa[64:1], decimal_exponent[79:65], saturated[80], zero pad
    output logic [dssp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int PAD_W = dssp_pkg::OUT_TDATA_W - dssp_pkg::OUT_FIELDS_W;

    // input register
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [dssp_pkg::CHAR_W-1:0]   s1_char_reg;
    logic                          s1_last_reg;

    // parse state
    dssp_pkg::parse_state_t        st_reg;
    dssp_pkg::parse_state_t        st_next;
    logic [MANTISSA_BITS-1:0]      mant_reg;
    logic [MANTISSA_BITS-1:0]      mant_next;

    // output register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [dssp_pkg::OUT_TDATA_W-1:0]   out_data_reg;

    // step results
    dssp_pkg::parse_state_t             step_st;
    logic [MANTISSA_BITS-1:0]           step_mant;
    logic [dssp_pkg::MANT_FIELD_W-1:0]  res_mantissa;
    logic [dssp_pkg::DEXP_W-1:0]        res_dexp;

    logic advance;
    logic load_out;
    logic take_in;

    dssp_step #(
        .MANTISSA_BITS  (MANTISSA_BITS),
        .EXPONENT_LIMIT (EXPONENT_LIMIT)
    ) u_step (
        .character    (s1_char_reg),
        .cur          (st_reg),
        .mant_cur     (mant_reg),
        .nxt          (step_st),
        .mant_nxt     (step_mant),
        .res_mantissa (res_mantissa),
        .res_dexp     (res_dexp)
    );

    // a held character moves on unless it closes a string and the result slot is full and not being taken
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || m_tready);
    assign load_out = advance && s1_last_reg;
    assign s_tready = !s1_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next  = take_in ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        st_next        = st_reg;
        mant_next      = mant_reg;
        if (advance)
        begin
            // a finished string leaves the parser in its reset state
            st_next   = s1_last_reg ? dssp_pkg::STATE_RESET : step_st;
            mant_next = s1_last_reg ? '0 : step_mant;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= dssp_pkg::STATE_RESET;
            mant_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
            mant_reg      <= mant_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_char_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        if (load_out)
            out_data_reg <= {{PAD_W{1'b0}}, step_st.clamp, res_dexp, res_mantissa,
                             step_st.sign_neg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/dssp_checker.sv =====
// port-level checks of the decimal string parser, bound to the top level
module dssp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dssp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a fresh result follows an accepted last character
    a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a closing character");

    // the input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no pending result");

    // exponent stays in range and padding is zero
    a_dexp_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[79:65]) >= -15'sd10254)
                  && ($signed(m_tdata[79:65]) <= 15'sd9999)
                  && (m_tdata[87:81] == 7'd0))
        else $error("decimal exponent out of range or padding set");

endmodule

bind decimal_scientific_string_parser_top dssp_checker u_dssp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
